// ===== rtl/business_day_date_advance_macros.svh =====
// Assertion macros for the business-day date advance block.
// Used by the top level; expects signals clk and rst in scope.
`ifndef BUSINESS_DAY_DATE_ADVANCE_MACROS_SVH
`define BUSINESS_DAY_DATE_ADVANCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdda_pkg.sv =====
// Package for the business-day date advance block: sequencer states,
// calendar constants and month tables. No dependencies.
package bdda_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVY,
    ST_REMY,
    ST_CHECK,
    ST_WDMUL,
    ST_WDREM,
    ST_WALK,
    ST_DONE
  } state_t;

  localparam logic [6:0]  MASK_RESET   = 7'd96;
  localparam logic [6:0]  MASK_ALL     = 7'h7f;
  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [13:0] RECIP_100    = 14'd5243;
  localparam logic [13:0] RECIP_7      = 14'd9362;
  localparam logic [6:0]  CENT_LAST    = 7'd99;
  localparam logic [3:0]  MONTH_JAN    = 4'd1;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [2:0]  WEEKDAY_LAST = 3'd6;

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1:    n = 5'd31;
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd3:    n = 5'd31;
      4'd4:    n = 5'd30;
      4'd5:    n = 5'd31;
      4'd6:    n = 5'd30;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd31;
      4'd9:    n = 5'd30;
      4'd10:   n = 5'd31;
      4'd11:   n = 5'd30;
      4'd12:   n = 5'd31;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // (31 * shifted month) / 12, March as month one
  function automatic logic [4:0] month_offset(input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd1:    n = 5'd28;
      4'd2:    n = 5'd31;
      4'd3:    n = 5'd2;
      4'd4:    n = 5'd5;
      4'd5:    n = 5'd7;
      4'd6:    n = 5'd10;
      4'd7:    n = 5'd12;
      4'd8:    n = 5'd15;
      4'd9:    n = 5'd18;
      4'd10:   n = 5'd20;
      4'd11:   n = 5'd23;
      4'd12:   n = 5'd25;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/business_day_date_advance.sv =====
// Top level of the business-day date advance block: sequencer, shared
// multiplier and calendar walk. Depends on bdda_pkg and the macros header.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_ready       start_year, start_month, start_day,
//                                                 business_days
//   out      output     out_valid / out_ready     return_year, return_month, return_day,
//                                                 start_weekday, date_valid
//   cfg      input      cfg_wr_en                 cfg_wr_data (weekend mask)
//
// After acceptance an item passes ST_DIVY, ST_REMY, ST_CHECK, ST_WDMUL and ST_WDREM, then
// walks calendar days in ST_WALK (about 1.4 x business_days with a two-day weekend) to
// ST_DONE; an invalid start date leaves ST_CHECK for ST_DONE, a fully masked week ST_WDREM.
// Setup runs a year split by 100 and a weekday remainder by 7 through one shared
// multiplier; the walk then advances one calendar day per cycle.
// in_ready is high only while idle; a result holds until out_ready takes it.
// rst clears the sequencer and sets the weekend mask to Friday and Saturday.
`include "business_day_date_advance_macros.svh"

module business_day_date_advance #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [13:0]            start_year,
  input  logic [3:0]             start_month,
  input  logic [4:0]             start_day,
  input  logic [COUNT_WIDTH-1:0] business_days,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [13:0]            return_year,
  output logic [3:0]             return_month,
  output logic [4:0]             return_day,
  output logic [2:0]             start_weekday,
  output logic                   date_valid,
  input  logic                   cfg_wr_en,
  input  logic [6:0]             cfg_wr_data
);
  import bdda_pkg::*;

  state_t                 state, state_next;
  logic [6:0]             mask;
  logic [13:0]            y, y_next;
  logic [3:0]             m, m_next;
  logic [4:0]             d, d_next;
  logic [COUNT_WIDTH-1:0] remain, remain_next;
  logic [2:0]             wd, wd_next;
  logic [2:0]             wd_start, wd_start_next;
  logic                   dvalid, dvalid_next;
  logic [6:0]             r100, r100_next;
  logic [7:0]             q100, q100_next;
  logic [14:0]            x, x_next;
  logic [28:0]            prod, prod_next;

  logic [14:0] mul_a;
  logic [13:0] mul_b;
  logic [28:0] mul_p;
  logic        leap;
  logic [4:0]  dim;
  logic        before_mar;
  logic [13:0] yy;
  logic [7:0]  qy;
  logic [7:0]  q_div;
  logic [12:0] q7;
  logic [3:0]  r7;
  logic        out_date_ok;

  assign mul_a = (state == ST_DIVY) ? {1'b0, y} : x;
  assign mul_b = (state == ST_DIVY) ? RECIP_100 : RECIP_7;
  assign mul_p = 29'(mul_a) * 29'(mul_b);

  assign leap = (y[1:0] == 2'd0) && ((r100 != 7'd0) || (q100[1:0] == 2'd0));
  assign dim  = days_in(m, leap);

  assign before_mar = (m == MONTH_JAN) || (m == MONTH_FEB);
  assign yy = before_mar ? (y - 14'd1) : y;
  assign qy = (before_mar && (r100 == 7'd0)) ? (q100 - 8'd1) : q100;

  assign q_div = prod[26:19];
  assign q7    = prod[28:16];
  assign r7    = 4'(x - 15'({2'b00, q7} * 15'd7));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mask  <= MASK_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        mask <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    y        <= y_next;
    m        <= m_next;
    d        <= d_next;
    remain   <= remain_next;
    wd       <= wd_next;
    wd_start <= wd_start_next;
    dvalid   <= dvalid_next;
    r100     <= r100_next;
    q100     <= q100_next;
    x        <= x_next;
    prod     <= prod_next;
  end

  always_comb begin
    state_next    = state;
    y_next        = y;
    m_next        = m;
    d_next        = d;
    remain_next   = remain;
    wd_next       = wd;
    wd_start_next = wd_start;
    dvalid_next   = dvalid;
    r100_next     = r100;
    q100_next     = q100;
    x_next        = x;
    prod_next     = prod;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          y_next      = start_year;
          m_next      = start_month;
          d_next      = start_day;
          remain_next = business_days;
          state_next  = ST_DIVY;
        end
      end
      ST_DIVY: begin
        prod_next  = mul_p;
        state_next = ST_REMY;
      end
      ST_REMY: begin
        q100_next  = q_div;
        r100_next  = 7'(y - 14'({6'd0, q_div} * 14'd100));
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        x_next = 15'(d) + 15'(yy) + 15'(yy[13:2]) - 15'(qy) + 15'(qy[7:2])
                 + 15'(month_offset(m));
        if ((y != 14'd0) && (y <= YEAR_MAX) && (dim != 5'd0) &&
            (d != 5'd0) && (d <= dim)) begin
          state_next = ST_WDMUL;
        end else begin
          wd_start_next = 3'd0;
          dvalid_next   = 1'b0;
          state_next    = ST_DONE;
        end
      end
      ST_WDMUL: begin
        prod_next  = mul_p;
        state_next = ST_WDREM;
      end
      ST_WDREM: begin
        wd_next       = (r7 >= 4'd7) ? 3'(r7 - 4'd7) : r7[2:0];
        wd_start_next = wd_next;
        dvalid_next   = 1'b1;
        state_next    = (mask == MASK_ALL) ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (remain == '0) begin
          state_next = ST_DONE;
        end else begin
          if (!mask[wd]) begin
            remain_next = remain - 1'b1;
          end
          if (d == dim) begin
            if (m == MONTH_DEC) begin
              if (y < YEAR_MAX) begin
                y_next = y + 14'd1;
                m_next = MONTH_JAN;
                d_next = 5'd1;
                if (r100 == CENT_LAST) begin
                  r100_next = 7'd0;
                  q100_next = q100 + 8'd1;
                end else begin
                  r100_next = r100 + 7'd1;
                end
              end
            end else begin
              m_next = m + 4'd1;
              d_next = 5'd1;
            end
          end else begin
            d_next = d + 5'd1;
          end
          wd_next = (wd == WEEKDAY_LAST) ? 3'd0 : (wd + 3'd1);
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign return_year   = y;
  assign return_month  = m;
  assign return_day    = d;
  assign start_weekday = wd_start;
  assign date_valid    = dvalid;

  assign out_date_ok = (m != 4'd0) && (m <= MONTH_DEC) && (d != 5'd0) &&
                       (wd_start <= WEEKDAY_LAST);

  `BDDA_ASSERT_NOW(a_ready_excl, out_valid, !in_ready, "in_ready high while a result waits")
  `BDDA_ASSERT_NEXT(a_no_early_out, in_valid && in_ready, !out_valid, "result right after accept")
  `BDDA_ASSERT_NOW(a_invalid_wd, out_valid && !date_valid, start_weekday == 3'd0, "bad weekday")
  `BDDA_ASSERT_NOW(a_valid_date, out_valid && date_valid, out_date_ok, "bad result date")

endmodule

// ===== sim/business_day_date_advance_checker.sv =====
// Scoreboard for the business-day date advance block: watches the item, result
// and weekend-mask ports, predicts each return date and compares it field by field.
// Depends on bdda_pkg for the calendar constants.
module business_day_date_advance_checker #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [13:0]            start_year,
  input  logic [3:0]             start_month,
  input  logic [4:0]             start_day,
  input  logic [COUNT_WIDTH-1:0] business_days,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [13:0]            return_year,
  input  logic [3:0]             return_month,
  input  logic [4:0]             return_day,
  input  logic [2:0]             start_weekday,
  input  logic                   date_valid,
  input  logic                   cfg_wr_en,
  input  logic [6:0]             cfg_wr_data,
  output int                     mismatches,
  output int                     pending
);
  import bdda_pkg::*;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic        valid;
  } return_date_t;

  return_date_t expected_dates[$];
  logic [6:0]   weekend_days;

  function automatic logic is_leap_year(input int unsigned y);
    return (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      MONTH_FEB:             return is_leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic return_date_t predict_return(input logic [13:0] year_in,
                                                  input logic [3:0] month_in,
                                                  input logic [4:0] day_in,
                                                  input logic [COUNT_WIDTH-1:0] count,
                                                  input logic [6:0] off_days);
    int unsigned  y, m, d, wd, used, shift, yy, mm;
    logic         ok;
    return_date_t r;
    y = year_in;
    m = month_in;
    d = day_in;
    ok = (y >= 1) && (y <= YEAR_MAX) && (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
         (d >= 1) && (d <= month_length(y, m));
    r.weekday = '0;
    if (ok) begin
      // shift January and February to the end of the previous year
      shift = (m <= MONTH_FEB) ? 1 : 0;
      yy = y - shift;
      mm = m + 12 * shift - 2;
      wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      r.weekday = 3'(wd);
      if (off_days != MASK_ALL) begin
        used = 0;
        while (used < count) begin
          if (!off_days[wd]) used++;
          if (d < month_length(y, m)) begin
            d++;
          end else if (m < MONTH_DEC) begin
            m++;
            d = 1;
          end else if (y < YEAR_MAX) begin
            y++;
            m = MONTH_JAN;
            d = 1;
          end
          wd = (wd + 1) % 7;
        end
      end
    end
    r.year  = 14'(y);
    r.month = 4'(m);
    r.day   = 5'(d);
    r.valid = ok;
    return r;
  endfunction

  function automatic int field_differs(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    return_date_t want;
    if (rst) begin
      weekend_days = MASK_RESET;
      mismatches = 0;
      expected_dates.delete();
    end else begin
      if (cfg_wr_en) weekend_days = cfg_wr_data;
      if (in_valid && in_ready)
        expected_dates.push_back(predict_return(start_year, start_month, start_day,
                                                business_days, weekend_days));
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          $error("result %0d-%0d-%0d with no item outstanding",
                 return_year, return_month, return_day);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          mismatches += field_differs("return_year", want.year, return_year);
          mismatches += field_differs("return_month", want.month, return_month);
          mismatches += field_differs("return_day", want.day, return_day);
          mismatches += field_differs("start_weekday", want.weekday, start_weekday);
          mismatches += field_differs("date_valid", want.valid, date_valid);
        end
      end
    end
    pending = expected_dates.size();
  end

endmodule

// ===== sim/business_day_date_advance_tb.sv =====
// Testbench top for the business-day date advance block: clock, reset, item and
// weekend-mask stimulus with random idling, and the verdict.
// Depends on bdda_pkg, the block and business_day_date_advance_checker.
module business_day_date_advance_tb;
  import bdda_pkg::*;

  localparam int COUNT_WIDTH     = 10;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int IDLE_PCT        = 27;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RUN_LIMIT       = 6000000;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   in_valid      = 1'b0;
  logic [13:0]            start_year    = '0;
  logic [3:0]             start_month   = '0;
  logic [4:0]             start_day     = '0;
  logic [COUNT_WIDTH-1:0] business_days = '0;
  logic                   out_ready     = 1'b0;
  logic                   cfg_wr_en     = 1'b0;
  logic [6:0]             cfg_wr_data   = '0;
  logic                   steady        = 1'b0;
  int unsigned            cycles        = 0;

  logic                   in_ready;
  logic                   out_valid;
  logic [13:0]            return_year;
  logic [3:0]             return_month;
  logic [4:0]             return_day;
  logic [2:0]             start_weekday;
  logic                   date_valid;
  int                     mismatches;
  int                     pending;

  business_day_date_advance #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_year    (start_year),
    .start_month   (start_month),
    .start_day     (start_day),
    .business_days (business_days),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .return_year   (return_year),
    .return_month  (return_month),
    .return_day    (return_day),
    .start_weekday (start_weekday),
    .date_valid    (date_valid),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  business_day_date_advance_checker #(.COUNT_WIDTH(COUNT_WIDTH)) scoreboard (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_year    (start_year),
    .start_month   (start_month),
    .start_day     (start_day),
    .business_days (business_days),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .return_year   (return_year),
    .return_month  (return_month),
    .return_day    (return_day),
    .start_weekday (start_weekday),
    .date_valid    (date_valid),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_item(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                           input logic [COUNT_WIDTH-1:0] n);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    start_year    <= y;
    start_month   <= m;
    start_day     <= d;
    business_days <= n;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random();
    int unsigned            pick;
    logic [13:0]            y;
    logic [3:0]             m;
    logic [4:0]             d;
    logic [COUNT_WIDTH-1:0] n;
    pick = $urandom_range(99);
    if (pick < 15) begin
      y = 14'($urandom_range(16383));
      m = 4'($urandom_range(15));
      d = 5'($urandom_range(31));
    end else begin
      pick = $urandom_range(99);
      if (pick < 15)      y = 14'($urandom_range(9999, 9990));
      else if (pick < 25) y = 14'($urandom_range(99, 1) * 100);
      else                y = 14'($urandom_range(9999, 1));
      m = 4'($urandom_range(12, 1));
      d = ($urandom_range(3) == 0) ? 5'($urandom_range(31, 28)) : 5'($urandom_range(28, 1));
    end
    pick = $urandom_range(99);
    if (pick < 80)      n = COUNT_WIDTH'($urandom_range(40));
    else if (pick < 92) n = COUNT_WIDTH'($urandom_range(300, 41));
    else                n = COUNT_WIDTH'($urandom_range(1023, 301));
    send_item(y, m, d, n);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_weekend(input logic [6:0] off_days);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= off_days;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [6:0] weekend;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_item(14'd2024, 4'd2, 5'd28, 10'd5);
    send_item(14'd1900, 4'd2, 5'd28, 10'd3);
    send_item(14'd2000, 4'd2, 5'd28, 10'd3);
    send_item(14'd1, 4'd1, 5'd1, 10'd0);
    send_item(14'd9999, 4'd12, 5'd31, 10'd1023);
    send_item(14'd9999, 4'd12, 5'd25, 10'd10);
    send_item(14'd2023, 4'd12, 5'd31, 10'd1023);
    send_item(14'd2023, 4'd1, 5'd31, 10'd1);
    send_item(14'd2024, 4'd2, 5'd29, 10'd1);
    send_item(14'd2023, 4'd2, 5'd29, 10'd1);
    send_item(14'd1900, 4'd2, 5'd29, 10'd1);
    send_item(14'd0, 4'd6, 5'd10, 10'd5);
    send_item(14'd10000, 4'd1, 5'd1, 10'd1);
    send_item(14'd16383, 4'd15, 5'd31, 10'd1023);
    send_item(14'd0, 4'd0, 5'd0, 10'd0);
    send_item(14'd2020, 4'd0, 5'd5, 10'd3);
    send_item(14'd2020, 4'd13, 5'd5, 10'd3);
    send_item(14'd2020, 4'd4, 5'd0, 10'd2);
    send_item(14'd2020, 4'd4, 5'd31, 10'd2);
    send_item(14'd2020, 4'd4, 5'd30, 10'd2);
    send_item(14'd2021, 4'd12, 5'd31, 10'd1);
    send_item(14'd2022, 4'd6, 5'd10, 10'd0);
    send_item(14'd2022, 4'd5, 5'd6, 10'd1);
    send_item(14'd2022, 4'd5, 5'd7, 10'd2);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       weekend = 7'h00;
        1:       weekend = MASK_ALL;
        2:       weekend = 7'h41;
        3:       weekend = 7'h3f;
        4:       weekend = 7'($urandom_range(127));
        default: weekend = MASK_RESET;
      endcase
      set_weekend(weekend);
      steady <= (p == 2);
      repeat (ITEMS_PER_PHASE) send_random();
    end

    wait_drained();
    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
